// ===== sv/mot_pkg.sv =====
package mot_pkg;

    localparam int unsigned NUM_AXES    = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned S_TDATA_W   = 32;
    localparam int unsigned M_TDATA_W   = 64;

    localparam logic [BYTE_W-1:0] BYTE_MAX      = 8'hff;
    localparam logic [BYTE_W-1:0] BYTE_MIN      = 8'h00;
    localparam logic [BYTE_W-1:0] DAC_MID       = 8'h80;
    localparam logic [BYTE_W-1:0] DAC_FOLD      = 8'h7f;
    localparam logic [BYTE_W-1:0] FIELD_CENTER  = 8'h80;
    localparam logic [BYTE_W-1:0] OFFSET_RESET  = 8'h80;
    localparam logic [BYTE_W-1:0] MIN_THR_RESET = 8'h00;
    localparam logic [BYTE_W-1:0] MAX_THR_RESET = 8'hff;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [2:0] {
        REG_MIN_THRESHOLD    = 3'd0,
        REG_MAX_THRESHOLD    = 3'd1,
        REG_SWAP_XY          = 3'd2,
        REG_FLIP_Z           = 3'd3,
        REG_MOUNT_ROTATION   = 3'd4,
        REG_INITIAL_OFFSET_X = 3'd5,
        REG_INITIAL_OFFSET_Y = 3'd6,
        REG_INITIAL_OFFSET_Z = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic swap_xy;
        logic flip_z;
        rot_t rotation;
    } orient_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] dac_code_z;
        logic [BYTE_W-1:0] dac_code_y;
        logic [BYTE_W-1:0] dac_code_x;
        logic              recalibrated;
        logic [BYTE_W-1:0] field_z;
        logic [BYTE_W-1:0] field_y;
        logic [BYTE_W-1:0] field_x;
        logic [BYTE_W-1:0] temperature;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ===== sv/mot_lane.sv =====
module mot_lane (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [mot_pkg::BYTE_W-1:0]     raw,
    input  logic [mot_pkg::BYTE_W-1:0]     min_threshold,
    input  logic [mot_pkg::BYTE_W-1:0]     max_threshold,
    input  logic                           advance,
    input  logic                           load,
    input  logic [mot_pkg::BYTE_W-1:0]     load_value,
    output logic                           hit,
    output logic [mot_pkg::BYTE_W-1:0]     dac_code
);

    logic [mot_pkg::BYTE_W-1:0] offset_reg;
    logic [mot_pkg::BYTE_W-1:0] offset_next;
    logic [mot_pkg::BYTE_W-1:0] offset_upd;
    logic                       raise;
    logic                       lower;

    assign raise = raw < min_threshold;
    assign lower = raw > max_threshold;
    assign hit   = raise | lower;

    always_comb begin
        offset_upd = offset_reg;
        if (raise && !lower && offset_reg != mot_pkg::BYTE_MAX) begin
            offset_upd = offset_reg + 8'd1;
        end else if (lower && !raise && offset_reg != mot_pkg::BYTE_MIN) begin
            offset_upd = offset_reg - 8'd1;
        end
    end

    assign dac_code = (offset_upd < mot_pkg::DAC_MID) ? (mot_pkg::DAC_FOLD - offset_upd)
                                                       : offset_upd;

    always_comb begin
        offset_next = offset_reg;
        if (load) begin
            offset_next = load_value;
        end else if (advance) begin
            offset_next = offset_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= mot_pkg::OFFSET_RESET;
        end else begin
            offset_reg <= offset_next;
        end
    end

endmodule

// ===== sv/mot_merge.sv =====
module mot_merge (
    input  logic [mot_pkg::BYTE_W-1:0]                        temp_raw,
    input  logic [mot_pkg::NUM_AXES-1:0][mot_pkg::BYTE_W-1:0] raw,
    input  logic [mot_pkg::NUM_AXES-1:0]                      hit,
    input  logic [mot_pkg::NUM_AXES-1:0][mot_pkg::BYTE_W-1:0] dac_code,
    input  mot_pkg::orient_cfg_t                              cfg,
    output mot_pkg::result_t                                  result
);

    logic [mot_pkg::BYTE_W-1:0] sx;
    logic [mot_pkg::BYTE_W-1:0] sy;
    logic [mot_pkg::BYTE_W-1:0] fz;
    logic [mot_pkg::BYTE_W-1:0] rx;
    logic [mot_pkg::BYTE_W-1:0] ry;

    always_comb begin
        sx = cfg.swap_xy ? raw[1] : raw[0];
        sy = cfg.swap_xy ? raw[0] : raw[1];
        fz = cfg.flip_z ? (mot_pkg::BYTE_MAX - raw[2]) : raw[2];
        case (cfg.rotation)
            mot_pkg::ROT_90: begin
                rx = sy;
                ry = mot_pkg::BYTE_MAX - sx;
            end
            mot_pkg::ROT_180: begin
                rx = mot_pkg::BYTE_MAX - sx;
                ry = mot_pkg::BYTE_MAX - sy;
            end
            mot_pkg::ROT_270: begin
                rx = mot_pkg::BYTE_MAX - sy;
                ry = sx;
            end
            default: begin
                rx = sx;
                ry = sy;
            end
        endcase
    end

    always_comb begin
        result.temperature  = temp_raw;
        result.field_x      = rx ^ mot_pkg::FIELD_CENTER;
        result.field_y      = ry ^ mot_pkg::FIELD_CENTER;
        result.field_z      = fz ^ mot_pkg::FIELD_CENTER;
        result.recalibrated = |hit;
        result.dac_code_x   = dac_code[0];
        result.dac_code_y   = dac_code[1];
        result.dac_code_z   = dac_code[2];
    end

endmodule

// ===== sv/mot_skid.sv =====
module mot_skid (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  mot_pkg::result_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output mot_pkg::result_t          out_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    mot_pkg::result_t out_data_reg;
    mot_pkg::result_t out_data_next;
    mot_pkg::result_t skid_data_reg;
    mot_pkg::result_t skid_data_next;
    logic             in_fire;
    logic             out_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== sv/magnetometer_offset_tracker.sv =====
// Magnetometer offset tracker.
// Input stream (s_*): one transaction carries a temperature byte and one raw
// three-axis field sample. Output stream (m_*): one transaction per input
// with the passed-through temperature, the oriented and centered field
// values, the recalibrated flag and the three offset DAC codes.
// Three identical lanes track the x, y and z offsets side by side; a merge
// stage applies swap/flip/rotation and ORs the lane threshold hits.
// Output or skid register holds each result. Throughput: one transaction
// per cycle unless stalled, set by the single compare-and-step per lane.
// A two-entry output buffer (output register plus skid register) keeps
// s_tready high while one result waits; s_tready drops only once both
// entries hold a result, and rises again the cycle after m_tready returns.
// Configuration goes through the APB port; writing an initial offset
// register also loads that lane's offset. Program it only while idle.
// Reset (aresetn low, synchronous): thresholds 0/255, no swap, no flip,
// no rotation, initial offsets and tracked offsets 128, output empty.
module magnetometer_offset_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // temp_raw[7:0], mag_x_raw[15:8], mag_y_raw[23:16], mag_z_raw[31:24]
    input  logic [mot_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // temperature[7:0], field_x[15:8], field_y[23:16], field_z[31:24],
    // recalibrated[32], dac_code_x[40:33], dac_code_y[48:41],
    // dac_code_z[56:49], zero[63:57]
    output logic [mot_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mot_pkg::ADDR_W-1:0]        paddr,
    input  logic [mot_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mot_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [mot_pkg::BYTE_W-1:0] min_threshold_reg;
    logic [mot_pkg::BYTE_W-1:0] min_threshold_next;
    logic [mot_pkg::BYTE_W-1:0] max_threshold_reg;
    logic [mot_pkg::BYTE_W-1:0] max_threshold_next;
    mot_pkg::orient_cfg_t       orient_reg;
    mot_pkg::orient_cfg_t       orient_next;
    logic [mot_pkg::NUM_AXES-1:0][mot_pkg::BYTE_W-1:0] init_offset_reg;
    logic [mot_pkg::NUM_AXES-1:0][mot_pkg::BYTE_W-1:0] init_offset_next;

    logic                       cfg_write;
    mot_pkg::reg_idx_t          cfg_idx;
    logic [mot_pkg::NUM_AXES-1:0] lane_load;

    logic                       in_fire;
    logic [mot_pkg::BYTE_W-1:0] temp_raw;
    logic [mot_pkg::NUM_AXES-1:0][mot_pkg::BYTE_W-1:0] raw;
    logic [mot_pkg::NUM_AXES-1:0]                      hit;
    logic [mot_pkg::NUM_AXES-1:0][mot_pkg::BYTE_W-1:0] dac_code;
    mot_pkg::result_t           result;
    mot_pkg::result_t           out_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = mot_pkg::reg_idx_t'(paddr[mot_pkg::ADDR_W-1:2]);

    assign lane_load[0] = cfg_write && (cfg_idx == mot_pkg::REG_INITIAL_OFFSET_X);
    assign lane_load[1] = cfg_write && (cfg_idx == mot_pkg::REG_INITIAL_OFFSET_Y);
    assign lane_load[2] = cfg_write && (cfg_idx == mot_pkg::REG_INITIAL_OFFSET_Z);

    always_comb begin
        min_threshold_next = min_threshold_reg;
        max_threshold_next = max_threshold_reg;
        orient_next        = orient_reg;
        init_offset_next   = init_offset_reg;
        if (cfg_write) begin
            case (cfg_idx)
                mot_pkg::REG_MIN_THRESHOLD:    min_threshold_next = pwdata[7:0];
                mot_pkg::REG_MAX_THRESHOLD:    max_threshold_next = pwdata[7:0];
                mot_pkg::REG_SWAP_XY:          orient_next.swap_xy = pwdata[0];
                mot_pkg::REG_FLIP_Z:           orient_next.flip_z = pwdata[0];
                mot_pkg::REG_MOUNT_ROTATION:   orient_next.rotation = mot_pkg::rot_t'(pwdata[1:0]);
                mot_pkg::REG_INITIAL_OFFSET_X: init_offset_next[0] = pwdata[7:0];
                mot_pkg::REG_INITIAL_OFFSET_Y: init_offset_next[1] = pwdata[7:0];
                mot_pkg::REG_INITIAL_OFFSET_Z: init_offset_next[2] = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_threshold_reg <= mot_pkg::MIN_THR_RESET;
            max_threshold_reg <= mot_pkg::MAX_THR_RESET;
            orient_reg        <= '{swap_xy: 1'b0, flip_z: 1'b0, rotation: mot_pkg::ROT_0};
            init_offset_reg   <= {mot_pkg::NUM_AXES{mot_pkg::OFFSET_RESET}};
        end else begin
            min_threshold_reg <= min_threshold_next;
            max_threshold_reg <= max_threshold_next;
            orient_reg        <= orient_next;
            init_offset_reg   <= init_offset_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            mot_pkg::REG_MIN_THRESHOLD:    prdata[7:0] = min_threshold_reg;
            mot_pkg::REG_MAX_THRESHOLD:    prdata[7:0] = max_threshold_reg;
            mot_pkg::REG_SWAP_XY:          prdata[0]   = orient_reg.swap_xy;
            mot_pkg::REG_FLIP_Z:           prdata[0]   = orient_reg.flip_z;
            mot_pkg::REG_MOUNT_ROTATION:   prdata[1:0] = orient_reg.rotation;
            mot_pkg::REG_INITIAL_OFFSET_X: prdata[7:0] = init_offset_reg[0];
            mot_pkg::REG_INITIAL_OFFSET_Y: prdata[7:0] = init_offset_reg[1];
            mot_pkg::REG_INITIAL_OFFSET_Z: prdata[7:0] = init_offset_reg[2];
            default:                       prdata      = '0;
        endcase
    end

    assign in_fire  = s_tvalid && s_tready;
    assign temp_raw = s_tdata[7:0];
    assign raw[0]   = s_tdata[15:8];
    assign raw[1]   = s_tdata[23:16];
    assign raw[2]   = s_tdata[31:24];

    for (genvar i = 0; i < mot_pkg::NUM_AXES; i++) begin : g_lane
        mot_lane u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .raw           (raw[i]),
            .min_threshold (min_threshold_reg),
            .max_threshold (max_threshold_reg),
            .advance       (in_fire),
            .load          (lane_load[i]),
            .load_value    (pwdata[7:0]),
            .hit           (hit[i]),
            .dac_code      (dac_code[i])
        );
    end

    mot_merge u_merge (
        .temp_raw (temp_raw),
        .raw      (raw),
        .hit      (hit),
        .dac_code (dac_code),
        .cfg      (orient_reg),
        .result   (result)
    );

    mot_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {{(mot_pkg::M_TDATA_W - mot_pkg::RESULT_W){1'b0}}, out_result};

endmodule

// ===== sv/mot_checker.sv =====
module mot_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [mot_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mot_pkg::M_TDATA_W-1:0]     m_tdata
);

    a_out_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_out_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    a_backpressure_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with empty output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty after reset");

    a_temp_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=>
            m_tvalid && (m_tdata[7:0] == $past(s_tdata[7:0])))
        else $error("temperature not passed on next cycle");

endmodule

bind magnetometer_offset_tracker mot_checker u_mot_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
